@@ rtl/dfc_pkg.sv @@
// dfc_pkg: constants, tables and shared types of the dfc block cipher
// no dependencies; used by dfc_round and dfc_block_cipher
package dfc_pkg;

  localparam int NumRoundsDefault = 8;
  localparam int SchedRounds      = 4;
  localparam int WordW            = 64;
  localparam int CfgIndexW        = 1;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIndexW-1:0] RegKeyLow  = 1'b1;

  localparam logic [3:0]  ModAdd    = 4'd13;
  localparam logic [31:0] XorConst  = 32'heb64749a;
  localparam logic [63:0] AddConst  = 64'h86d1bf275b9b241d;

  // key padding words
  localparam logic [31:0] PadWord [4] = '{
    32'hda06c80a, 32'hbb1185eb, 32'h4f7c7b57, 32'h57f59584
  };

  // per-round xor masks of the key schedule chains, first round unmasked
  localparam logic [63:0] SchedAXor [SchedRounds] = '{
    64'h0, 64'hb7e151628aed2a6a, 64'hbf7158809cf4f3c7, 64'h62e7160f38b4da56
  };
  localparam logic [63:0] SchedBXor [SchedRounds] = '{
    64'h0, 64'ha784d9045190cfef, 64'h324e7738926cfbe5, 64'hf4bf8d8d8c31d763
  };

  localparam logic [31:0] PermTable [64] = '{
    32'hb7e15162, 32'h8aed2a6a, 32'hbf715880, 32'h9cf4f3c7,
    32'h62e7160f, 32'h38b4da56, 32'ha784d904, 32'h5190cfef,
    32'h324e7738, 32'h926cfbe5, 32'hf4bf8d8d, 32'h8c31d763,
    32'hda06c80a, 32'hbb1185eb, 32'h4f7c7b57, 32'h57f59584,
    32'h90cfd47d, 32'h7c19bb42, 32'h158d9554, 32'hf7b46bce,
    32'hd55c4d79, 32'hfd5f24d6, 32'h613c31c3, 32'h839a2ddf,
    32'h8a9a276b, 32'hcfbfa1c8, 32'h77c56284, 32'hdab79cd4,
    32'hc2b3293d, 32'h20e9e5ea, 32'hf02ac60a, 32'hcc93ed87,
    32'h4422a52e, 32'hcb238fee, 32'he5ab6add, 32'h835fd1a0,
    32'h753d0a8f, 32'h78e537d2, 32'hb95bb79d, 32'h8dcaec64,
    32'h2c1e9f23, 32'hb829b5c2, 32'h780bf387, 32'h37df8bb3,
    32'h00d01334, 32'ha0d0bd86, 32'h45cbfa73, 32'ha6160ffe,
    32'h393c48cb, 32'hbbca060f, 32'h0ff8ec6d, 32'h31beb5cc,
    32'heed7f2f0, 32'hbb088017, 32'h163bc60d, 32'hf45a0ecb,
    32'h1bcd289b, 32'h06cbbfea, 32'h21ad08e1, 32'h847f3f73,
    32'h78d56ced, 32'h94640d6e, 32'hf0d3d37b, 32'he67008e1
  };

  // stage enables of the round unit
  typedef struct packed {
    logic mul;
    logic sum;
    logic red1;
    logic red2;
  } round_ctrl_t;

endpackage

@@ rtl/dfc_key_ram.sv @@
// dfc_key_ram: round key store, one write and one registered read port
// depends on nothing
module dfc_key_ram #(
  parameter int Depth = 16,
  parameter int Width = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dfc_round.sv @@
// dfc_round: staged round function, (a*x+b) mod (2^64+13) then confusion
// depends on dfc_pkg
module dfc_round (
  input  logic                  clk,
  input  dfc_pkg::round_ctrl_t  ctrl,
  input  logic [63:0]           a,
  input  logic [63:0]           x,
  input  logic [63:0]           b,
  output logic [63:0]           f
);

  logic [63:0]  p0, p1, p2, p3;
  logic [127:0] prod;
  logic [64:0]  lo_sum;
  logic [63:0]  lo2, hi2;
  logic [67:0]  c;
  logic [63:0]  d;
  logic [4:0]   n;
  logic [64:0]  s_sum;
  logic [63:0]  s, y;
  logic [31:0]  left, right;

  // partial products, four 32x32 multipliers
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      p0 <= 64'(a[31:0])  * 64'(x[31:0]);
      p1 <= 64'(a[31:0])  * 64'(x[63:32]);
      p2 <= 64'(a[63:32]) * 64'(x[31:0]);
      p3 <= 64'(a[63:32]) * 64'(x[63:32]);
    end
  end

  always_comb begin
    prod   = {64'h0, p0} + {32'h0, p1, 32'h0} + {32'h0, p2, 32'h0} + {p3, 64'h0};
    lo_sum = {1'b0, prod[63:0]} + {1'b0, b};
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      lo2 <= lo_sum[63:0];
      hi2 <= prod[127:64] + 64'(lo_sum[64]);
    end
  end

  // fold the high word: 2^64 = -13
  always_comb begin
    c = 68'(hi2) * 68'(dfc_pkg::ModAdd);
  end

  always_ff @(posedge clk) begin
    if (ctrl.red1) begin
      d <= lo2 - c[63:0];
      n <= 5'(c[67:64]) + 5'(lo2 < c[63:0]);
    end
  end

  always_comb begin
    s_sum = {1'b0, d} + 65'(n * 9'(dfc_pkg::ModAdd));
    s     = s_sum[63:0];
    if (s_sum[64] && (s >= 64'(dfc_pkg::ModAdd))) begin
      y = s - 64'(dfc_pkg::ModAdd);
    end else begin
      y = s;
    end
    left  = y[31:0] ^ dfc_pkg::PermTable[y[63:58]];
    right = y[63:32] ^ dfc_pkg::XorConst;
  end

  always_ff @(posedge clk) begin
    if (ctrl.red2) begin
      f <= {left, right} + dfc_pkg::AddConst;
    end
  end

endmodule

@@ rtl/dfc_block_cipher.sv @@
// dfc_block_cipher: top level, sequencer, key schedule and stream ports
// depends on dfc_pkg, dfc_key_ram, dfc_round
//
//  channel  dir  signals                          content
//  s_*      in   tvalid tready tdata tuser        one block to encrypt or decrypt
//  m_*      out  tvalid tready tdata              the processed block
//  cfg_*    in   we index data                    key registers
//
// each round passes through the shared round unit: read a, multiply and read b,
// add b, two reduction steps, feistel update
// after reset or a key write the first block first rebuilds the round keys; each
// key pair comes from a chain of key schedule rounds and is then written to the ram
// one block is worked at a time; the next is taken while the result waits
// synchronous active-high reset clears control, the key registers and the key-ready flag
module dfc_block_cipher #(
  parameter int NUM_ROUNDS = dfc_pkg::NumRoundsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [127:0]                  s_tdata,   // block_low, block_high (block_high in bits 63:0)
  input  logic                          s_tuser,   // operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [127:0]                  m_tdata,   // result_low, result_high (result_high in bits 63:0)
  input  logic                          cfg_we,
  input  logic [dfc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  localparam int RW    = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
  localparam int AW    = RW + 1;
  localparam int Depth = 2 * NUM_ROUNDS;
  localparam int SW    = $clog2(dfc_pkg::SchedRounds);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RA   = 10'b0000000010,
    S_MUL  = 10'b0000000100,
    S_SUM  = 10'b0000001000,
    S_RED1 = 10'b0000010000,
    S_RED2 = 10'b0000100000,
    S_UPD  = 10'b0001000000,
    S_WK0  = 10'b0010000000,
    S_WK1  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state;

  logic [63:0]   key_high, key_low;
  logic          keys_ready;
  logic          key_mode;
  logic          dec;
  logic [63:0]   blk_hi, blk_lo;
  logic [63:0]   prev, cur;
  logic [RW-1:0] rnd, kit, k;
  logic [SW-1:0] sr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  dfc_pkg::round_ctrl_t rctrl;
  logic [63:0]   op_a, op_b, f;
  logic [63:0]   set_a, set_b;

  // key schedule chain keys, odd and even sets alternate by iteration
  always_comb begin
    if (kit[0]) begin
      set_a = {key_high[31:0], dfc_pkg::PadWord[2]};
      set_b = {dfc_pkg::PadWord[1], key_low[63:32]};
    end else begin
      set_a = {key_high[63:32], dfc_pkg::PadWord[3]};
      set_b = {dfc_pkg::PadWord[0], key_low[31:0]};
    end
  end

  // decryption walks the round keys backward
  assign k = dec ? (RW'(NUM_ROUNDS - 1) - rnd) : rnd;

  always_comb begin
    ram_raddr = (state == S_RA) ? {k, 1'b0} : {k, 1'b1};
    ram_we    = (state == S_WK0) || (state == S_WK1);
    ram_waddr = (state == S_WK0) ? {kit, 1'b0} : {kit, 1'b1};
    ram_wdata = (state == S_WK0) ? cur : prev;
    op_a      = key_mode ? (set_a ^ dfc_pkg::SchedAXor[sr]) : ram_rdata;
    op_b      = key_mode ? (set_b ^ dfc_pkg::SchedBXor[sr]) : ram_rdata;
    rctrl.mul  = (state == S_MUL);
    rctrl.sum  = (state == S_SUM);
    rctrl.red1 = (state == S_RED1);
    rctrl.red2 = (state == S_RED2);
  end

  dfc_key_ram #(.Depth(Depth), .Width(64), .AddrW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dfc_round u_round (
    .clk  (clk),
    .ctrl (rctrl),
    .a    (op_a),
    .x    (cur),
    .b    (op_b),
    .f    (f)
  );

  assign s_tready = (state == S_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      keys_ready <= 1'b0;
      key_mode   <= 1'b0;
      m_tvalid   <= 1'b0;
      key_high   <= '0;
      key_low    <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      // a key write clears the ready flag so the next block rebuilds the keys
      if (cfg_we) begin
        case (cfg_index)
          dfc_pkg::RegKeyHigh: begin
            key_high   <= cfg_data;
            keys_ready <= 1'b0;
          end
          dfc_pkg::RegKeyLow: begin
            key_low    <= cfg_data;
            keys_ready <= 1'b0;
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            key_mode <= !keys_ready;
            state    <= S_RA;
          end
        end
        S_RA:   state <= S_MUL;
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_RED1;
        S_RED1: state <= S_RED2;
        S_RED2: state <= S_UPD;
        S_UPD: begin
          if (key_mode) begin
            state <= (sr == SW'(dfc_pkg::SchedRounds - 1)) ? S_WK0 : S_RA;
          end else begin
            state <= (rnd == RW'(NUM_ROUNDS - 1)) ? S_DONE : S_RA;
          end
        end
        S_WK0: state <= S_WK1;
        S_WK1: begin
          if (kit == RW'(NUM_ROUNDS - 1)) begin
            keys_ready <= 1'b1;
            key_mode   <= 1'b0;
          end
          state <= S_RA;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          dec    <= s_tuser;
          blk_hi <= s_tdata[63:0];
          blk_lo <= s_tdata[127:64];
          rnd    <= '0;
          kit    <= '0;
          sr     <= '0;
          if (keys_ready) begin
            prev <= s_tdata[63:0];
            cur  <= s_tdata[127:64];
          end else begin
            prev <= '0;
            cur  <= '0;
          end
        end
      end
      S_UPD: begin
        prev <= cur;
        cur  <= f ^ prev;
        if (key_mode) begin
          sr <= sr + SW'(1);
        end else begin
          rnd <= rnd + RW'(1);
        end
      end
      S_WK1: begin
        if (kit == RW'(NUM_ROUNDS - 1)) begin
          prev <= blk_hi;
          cur  <= blk_lo;
        end else begin
          // next chain starts from this chain's output pair
          prev <= cur;
          cur  <= prev;
          kit  <= kit + RW'(1);
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {prev, cur};
        end
      end
      default: ;
    endcase
  end

endmodule

@@ bench/dfc_block_cipher_check.sv @@
// dfc_block_cipher_check: watches the block and key ports, predicts each
// processed block and compares it; depends on dfc_pkg for the cipher tables
`timescale 1ns / 100ps

module dfc_block_cipher_check (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  input  logic         cfg_we,
  input  logic [dfc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [63:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  localparam int Rounds = dfc_pkg::NumRoundsDefault;
  localparam logic OpDecrypt = 1'b1;

  logic [63:0]  key_hi, key_lo;
  logic [63:0]  sched_keys [2*Rounds];
  bit           sched_valid;
  logic [127:0] expected_blocks [$];

  function automatic logic [63:0] mod_mul_add(logic [63:0] a, logic [63:0] x,
                                              logic [63:0] b);
    logic [129:0] full;
    full = ({66'd0, a} * {66'd0, x} + {66'd0, b}) % ((130'd1 << 64) + 130'd13);
    return full[63:0];
  endfunction

  function automatic logic [63:0] round_f(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] x);
    logic [63:0] y;
    logic [31:0] lf, rt;
    y  = mod_mul_add(a, x, b);
    lf = y[31:0] ^ dfc_pkg::PermTable[y[63:58]];
    rt = y[63:32] ^ dfc_pkg::XorConst;
    return {lf, rt} + dfc_pkg::AddConst;
  endfunction

  // rebuild round keys from the two key registers
  task automatic build_keys();
    logic [31:0] w [8];
    logic [63:0] odd_k [8], even_k [8];
    logic [63:0] h, l, nx;
    w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
    w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
    for (int i = 0; i < 4; i++) w[4+i] = dfc_pkg::PadWord[i];
    for (int i = 0; i < dfc_pkg::SchedRounds; i++) begin
      odd_k[2*i]    = {w[0], w[7]} ^ dfc_pkg::SchedAXor[i];
      odd_k[2*i+1]  = {w[4], w[3]} ^ dfc_pkg::SchedBXor[i];
      even_k[2*i]   = {w[1], w[6]} ^ dfc_pkg::SchedAXor[i];
      even_k[2*i+1] = {w[5], w[2]} ^ dfc_pkg::SchedBXor[i];
    end
    h = 0; l = 0;
    for (int r = 0; r < Rounds; r++) begin
      // chain: prev=h, cur=l
      for (int j = 0; j < dfc_pkg::SchedRounds; j++) begin
        if (r % 2) nx = round_f(even_k[2*j], even_k[2*j+1], l) ^ h;
        else       nx = round_f(odd_k[2*j], odd_k[2*j+1], l) ^ h;
        h = l; l = nx;
      end
      // chain output hi=cur, lo=prev
      nx = h; h = l; l = nx;
      sched_keys[2*r] = h; sched_keys[2*r+1] = l;
    end
    sched_valid = 1;
  endtask

  // block_high in the low half, result_high back in the low half
  function automatic logic [127:0] cipher_block(logic dec, logic [127:0] blk);
    logic [63:0] prv, cur, nx;
    int k;
    prv = blk[63:0]; cur = blk[127:64];
    for (int i = 0; i < Rounds; i++) begin
      k = dec ? Rounds - 1 - i : i;
      nx = round_f(sched_keys[2*k], sched_keys[2*k+1], cur) ^ prv;
      prv = cur; cur = nx;
    end
    return {prv, cur};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key_hi <= 0; key_lo <= 0; sched_valid = 0;
      fail_count <= 0;
      pending <= 0;
      expected_blocks.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == dfc_pkg::RegKeyHigh) begin
          key_hi <= cfg_data; sched_valid = 0;
        end else if (cfg_index == dfc_pkg::RegKeyLow) begin
          key_lo <= cfg_data; sched_valid = 0;
        end
      end
      if (s_tvalid && s_tready) begin
        if (!sched_valid) build_keys();
        expected_blocks.push_back(cipher_block(s_tuser == OpDecrypt, s_tdata));
      end
      if (m_tvalid && m_tready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected block, expected none, actual %h", $time, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          if (m_tdata[63:0] !== expected_blocks[0][63:0]) begin
            $display("%0t: result_high expected %h actual %h", $time,
                     expected_blocks[0][63:0], m_tdata[63:0]);
            fail_count <= fail_count + 1;
          end else if (m_tdata[127:64] !== expected_blocks[0][127:64]) begin
            $display("%0t: result_low expected %h actual %h", $time,
                     expected_blocks[0][127:64], m_tdata[127:64]);
            fail_count <= fail_count + 1;
          end
          void'(expected_blocks.pop_front());
        end
      end
      pending <= expected_blocks.size();
    end
  end
endmodule

@@ bench/dfc_block_cipher_test.sv @@
// dfc_block_cipher_test: stimulus, clock, reset and verdict for the cipher
// depends on dfc_pkg, dfc_block_cipher and dfc_block_cipher_check
`timescale 1ns / 100ps

module dfc_block_cipher_test;

  localparam int RandomItems = 830;
  localparam longint CycleLimit = 1500000;
  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0, s_tuser = 0, m_tready = 0;
  logic [127:0] s_tdata = '0;
  logic cfg_we = 0;
  logic [dfc_pkg::CfgIndexW-1:0] cfg_index = dfc_pkg::RegKeyHigh;
  logic [63:0] cfg_data = '0;
  logic s_tready, m_tvalid;
  logic [127:0] m_tdata;
  int fail_count, pending;
  longint cycle_count = 0;

  // receiver behavior: 0 random stalls, 1 never stall, 2 long hold-off
  int sink_mode = 0;
  bit sender_calm = 0;

  always #5 clk = ~clk;

  dfc_block_cipher dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  dfc_block_cipher_check checker_i (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls, never stalling, or a long hold-off counted in cycles
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (sink_mode == 2) begin
        m_tready <= 0;
        hold = 0;
        while (hold < 400) begin
          @(posedge clk);
          hold++;
        end
        sink_mode = 0;
      end else if (sink_mode == 1) m_tready <= 1;
      else m_tready <= ($urandom_range(99) >= 15);
    end
  end

  // one write, then cfg_we is deasserted before anything else is driven
  task automatic write_key(logic [dfc_pkg::CfgIndexW-1:0] idx, logic [63:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // offer one item, idle at random first unless the sender is calm, hold until accepted
  task automatic send_block(logic op, logic [127:0] blk);
    if (!sender_calm)
      while ($urandom_range(99) < 15) begin
        s_tvalid <= 0;
        @(posedge clk);
      end
    s_tvalid <= 1; s_tuser <= op; s_tdata <= blk;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random word with a bias toward extremes and sparse patterns
  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      3: return ~(64'd1 << $urandom_range(63));
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [127:0] blk;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: reset key (all zero), extremes of block, both operations
    send_block(OpEncrypt, '0);
    send_block(OpDecrypt, '0);
    send_block(OpEncrypt, '1);
    send_block(OpDecrypt, '1);
    send_block(OpEncrypt, {64'h0123456789abcdef, 64'hfedcba9876543210});
    send_block(OpDecrypt, {64'h8000000000000000, 64'h1});
    drain();
    // all-ones key, then one key write while keys already built
    write_key(dfc_pkg::RegKeyHigh, '1);
    write_key(dfc_pkg::RegKeyLow, '1);
    send_block(OpEncrypt, '0);
    send_block(OpDecrypt, '1);
    send_block(OpEncrypt, {64'h1, 64'h8000000000000000});
    drain();
    write_key(dfc_pkg::RegKeyLow, 64'h0);
    send_block(OpDecrypt, {64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
    send_block(OpEncrypt, {64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
    drain();

    // random phases with a fresh key each time, all zero in the last phase
    for (int ph = 0; ph < 10; ph++) begin
      write_key(dfc_pkg::RegKeyHigh, (ph == 9) ? 64'h0 : rand_word());
      write_key(dfc_pkg::RegKeyLow, (ph == 9) ? 64'h0 : rand_word());
      // quiet phase: no idling on either side
      sender_calm = (ph == 3);
      sink_mode = (ph == 3) ? 1 : 0;
      for (int i = 0; i < RandomItems / 10; i++) begin
        if (ph == 5 && i == 10) sink_mode = 2;
        blk = {rand_word(), rand_word()};
        send_block(1'($urandom_range(1)), blk);
      end
      sender_calm = 0;
      sink_mode = 0;
      drain();
    end

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
